// File: design/one_wire_backlight_sender_macros.svh
// Assertion macros of the one-wire backlight sender, used by owb_seq.
// The macros expect a signal named clk, OWB_ASSERT also one named rst.
`ifndef ONE_WIRE_BACKLIGHT_SENDER_MACROS_SVH
`define ONE_WIRE_BACKLIGHT_SENDER_MACROS_SVH

// Property checked at every rising edge, switched off while reset is high.
`define OWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define OWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/owb_pkg.sv
// Package for the one-wire backlight sender: register indexes, reset values,
// the configuration struct and the sequencer states. No dependencies.
`default_nettype none

package owb_pkg;

  localparam int LEVEL_W    = 8;
  localparam int HOLD_W     = 16;
  localparam int ADDR_W     = 8;
  localparam int MAX_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DATA_BITS  = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS   = 3'd0,
    REG_SHORT_US         = 3'd1,
    REG_LONG_US          = 3'd2,
    REG_SELECT_HIGH_US   = 3'd3,
    REG_SELECT_LOW_US    = 3'd4,
    REG_SELECT_SETTLE_US = 3'd5,
    REG_OFF_HOLD_US      = 3'd6,
    REG_MAX_LEVEL        = 3'd7
  } cfg_reg_t;

  // Values after reset.
  localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS   = 8'h72;
  localparam logic [HOLD_W-1:0] RST_SHORT_US         = 16'd10;
  localparam logic [HOLD_W-1:0] RST_LONG_US          = 16'd180;
  localparam logic [HOLD_W-1:0] RST_SELECT_HIGH_US   = 16'd120;
  localparam logic [HOLD_W-1:0] RST_SELECT_LOW_US    = 16'd280;
  localparam logic [HOLD_W-1:0] RST_SELECT_SETTLE_US = 16'd650;
  localparam logic [HOLD_W-1:0] RST_OFF_HOLD_US      = 16'd3000;
  localparam logic [MAX_W-1:0]  RST_MAX_LEVEL        = 6'd32;

  typedef struct packed {
    logic [ADDR_W-1:0] device_address;
    logic [HOLD_W-1:0] short_us;
    logic [HOLD_W-1:0] long_us;
    logic [HOLD_W-1:0] select_high_us;
    logic [HOLD_W-1:0] select_low_us;
    logic [HOLD_W-1:0] select_settle_us;
    logic [HOLD_W-1:0] off_hold_us;
    logic [MAX_W-1:0]  max_level;
  } cfg_t;

  // Segment sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFF,
    ST_SEL_HIGH,
    ST_SEL_LOW,
    ST_SEL_SETTLE,
    ST_START,
    ST_BIT_LO,
    ST_BIT_HI,
    ST_END,
    ST_RELEASE
  } state_t;

endpackage

`default_nettype wire

// File: design/one_wire_backlight_sender.sv
// Top level of the one-wire backlight sender.
// Instantiates owb_cfg_regs and owb_seq; depends on owb_pkg.
//
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata) takes one backlight level
// request per item. The master channel (m_tvalid, m_tready, m_tdata, m_tlast)
// gives the pin segments of that request, one item per segment, with m_tlast
// on the final one. The cfg channel writes one timing or address register per
// item and is always ready; write it only while no request is under way.
// The request is registered into the sequencer state; its first segment then
// passes through the output register. Throughput: one segment per cycle while
// the receiver does not stall. An off request gives one segment, a level
// request two framed bytes, or the mode-select sequence and then two bytes.
// s_tready is low while a request's segments are being produced.
// Reset loads the register defaults, marks the mode as already selected and
// empties the output register.
// When the receiver stalls, the output register holds its segment and the
// sequencer waits; nothing is lost or repeated.
`default_nettype none

module one_wire_backlight_sender
  import owb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] level
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [0] pin_level, [16:1] hold_us, [23:17] zero
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              pin_level;
  logic [HOLD_W-1:0] hold_us;

  owb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .level     (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pin_level (pin_level),
    .hold_us   (hold_us),
    .last      (m_tlast)
  );

  // Pack the segment fields, lowest field first.
  assign m_tdata = {7'd0, hold_us, pin_level};

endmodule

`default_nettype wire

// File: design/owb_cfg_regs.sv
// Configuration register file of the one-wire backlight sender.
// Depends on owb_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module owb_cfg_regs
  import owb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes, decoded by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address   <= RST_DEVICE_ADDRESS;
      cfg.short_us         <= RST_SHORT_US;
      cfg.long_us          <= RST_LONG_US;
      cfg.select_high_us   <= RST_SELECT_HIGH_US;
      cfg.select_low_us    <= RST_SELECT_LOW_US;
      cfg.select_settle_us <= RST_SELECT_SETTLE_US;
      cfg.off_hold_us      <= RST_OFF_HOLD_US;
      cfg.max_level        <= RST_MAX_LEVEL;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEVICE_ADDRESS:   cfg.device_address   <= cfg_data[ADDR_W-1:0];
        REG_SHORT_US:         cfg.short_us         <= cfg_data;
        REG_LONG_US:          cfg.long_us          <= cfg_data;
        REG_SELECT_HIGH_US:   cfg.select_high_us   <= cfg_data;
        REG_SELECT_LOW_US:    cfg.select_low_us    <= cfg_data;
        REG_SELECT_SETTLE_US: cfg.select_settle_us <= cfg_data;
        REG_OFF_HOLD_US:      cfg.off_hold_us      <= cfg_data;
        REG_MAX_LEVEL:        cfg.max_level        <= cfg_data[MAX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/owb_seq.sv
// Segment sequencer: saturates the level, shifts each byte out one bit at a
// time and loads one pin segment per cycle into the output register while
// the receiver does not stall. Depends on owb_pkg and the macros header.
`default_nettype none
`include "one_wire_backlight_sender_macros.svh"

module owb_seq
  import owb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LEVEL_W-1:0] level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               pin_level,
  output logic [HOLD_W-1:0]  hold_us,
  output logic               last
);

  state_t                 state, state_next;
  logic                   mode_sel;
  logic [2:0]             bit_cnt;
  logic [ADDR_W-1:0]      shift;
  logic [DATA_BITS-1:0]   data_byte;
  logic                   second;
  logic [LEVEL_W-1:0]     lvl_sat;
  logic                   accept;
  logic                   adv;
  logic                   seg_pin;
  logic [HOLD_W-1:0]      seg_hold;
  logic                   seg_last;
  logic                   cur_bit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign adv      = !out_valid || out_ready;
  assign cur_bit  = shift[ADDR_W-1];

  // Saturate the request to max_level.
  assign lvl_sat = (level > {2'b00, cfg.max_level}) ? {2'b00, cfg.max_level} : level;

  // Next state and the segment that the current state emits.
  always_comb begin
    state_next = state;
    seg_pin    = 1'b0;
    seg_hold   = '0;
    seg_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (lvl_sat == '0)  state_next = ST_OFF;
          else if (!mode_sel) state_next = ST_SEL_HIGH;
          else                state_next = ST_START;
        end
      end
      ST_OFF: begin
        seg_pin  = 1'b0;
        seg_hold = cfg.off_hold_us;
        seg_last = 1'b1;
        if (adv) state_next = ST_IDLE;
      end
      ST_SEL_HIGH: begin
        seg_pin  = 1'b1;
        seg_hold = cfg.select_high_us;
        if (adv) state_next = ST_SEL_LOW;
      end
      ST_SEL_LOW: begin
        seg_pin  = 1'b0;
        seg_hold = cfg.select_low_us;
        if (adv) state_next = ST_SEL_SETTLE;
      end
      ST_SEL_SETTLE: begin
        seg_pin  = 1'b1;
        seg_hold = cfg.select_settle_us;
        if (adv) state_next = ST_START;
      end
      ST_START: begin
        seg_pin  = 1'b1;
        seg_hold = cfg.short_us;
        if (adv) state_next = ST_BIT_LO;
      end
      ST_BIT_LO: begin
        seg_pin  = 1'b0;
        seg_hold = cur_bit ? cfg.short_us : cfg.long_us;
        if (adv) state_next = ST_BIT_HI;
      end
      ST_BIT_HI: begin
        seg_pin  = 1'b1;
        seg_hold = cur_bit ? cfg.long_us : cfg.short_us;
        if (adv) state_next = (bit_cnt == 3'd7) ? ST_END : ST_BIT_LO;
      end
      ST_END: begin
        seg_pin  = 1'b0;
        seg_hold = cfg.short_us;
        if (adv) state_next = ST_RELEASE;
      end
      ST_RELEASE: begin
        seg_pin  = 1'b1;
        seg_hold = '0;
        seg_last = second;
        if (adv) state_next = second ? ST_IDLE : ST_START;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register and mode flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode_sel <= 1'b1;
    end else begin
      state <= state_next;
      if (accept) mode_sel <= (lvl_sat != '0);
    end
  end

  // Bit shifter: address byte first, then the data byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
      second  <= 1'b0;
    end else if (accept) begin
      bit_cnt   <= '0;
      second    <= 1'b0;
      shift     <= cfg.device_address;
      data_byte <= DATA_BITS'(lvl_sat - 8'd1);
    end else if (adv) begin
      if (state == ST_BIT_HI) begin
        bit_cnt <= bit_cnt + 3'd1;
        shift   <= {shift[ADDR_W-2:0], 1'b0};
      end else if (state == ST_RELEASE && !second) begin
        second <= 1'b1;
        shift  <= {{(ADDR_W-DATA_BITS){1'b0}}, data_byte};
      end
    end
  end

  // Output register: parts the sequencer from the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= (state != ST_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && state != ST_IDLE) begin
      pin_level <= seg_pin;
      hold_us   <= seg_hold;
      last      <= seg_last;
    end
  end

  `OWB_ASSERT(a_last_ends_run, (adv && state != ST_IDLE && seg_last) |=> state == ST_IDLE, "last segment did not return to idle")
  `OWB_ASSERT(a_off_path, (accept && lvl_sat == '0) |=> state == ST_OFF, "zero level did not take the off path")
  `OWB_ASSERT(a_bit_step, (adv && state == ST_BIT_HI && bit_cnt != 3'd7) |=> bit_cnt == 3'($past(bit_cnt) + 3'd1), "bit counter did not step")
  `OWB_ASSERT(a_mode_before_byte, (state == ST_START) |-> mode_sel, "byte framing started without mode selected")

endmodule

`default_nettype wire

// File: tb/sv/tb_one_wire_backlight_sender.sv
// Self-checking testbench for one_wire_backlight_sender: directed table, then random requests.
// Each pin segment is checked against a predictor of the segment runs.
// Depends on owb_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_one_wire_backlight_sender;
  import owb_pkg::*;

  // One pin segment as it leaves the block.
  typedef struct packed {
    logic              pin;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } segment_t;

  // Row kinds of the directed table. An off row carries the expected hold typed in.
  typedef enum logic [1:0] {ROW_REQ, ROW_OFF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_reg_t          idx;
    logic [15:0]       arg;   // level for requests, write data for registers
    logic [HOLD_W-1:0] hold;  // expected off hold on off rows
  } dir_row_t;

  localparam int DIR_ROWS   = 34;
  localparam int RAND_ITEMS = 410;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] level
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;        // [0] pin_level, [16:1] hold_us, [23:17] zero
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: register copy, mode flag and the segments still due.
  cfg_t     timing;
  logic     mode_selected_copy;
  segment_t segments_due[$];

  // Idle-free stretch for both sides.
  logic calm = 1'b0;

  int err_count    = 0;
  int n_requests   = 0;
  int n_off        = 0;
  int n_select     = 0;
  int n_segments   = 0;
  int n_cfg_writes = 0;

  dir_row_t script [DIR_ROWS];

  one_wire_backlight_sender u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  function automatic void queue_segment(input logic pin, input logic [HOLD_W-1:0] hold);
    segments_due.push_back('{pin, hold, 1'b0});
  endfunction

  // A framed byte, most significant bit first.
  function automatic void queue_byte(input logic [7:0] value);
    queue_segment(1'b1, timing.short_us);
    for (int b = 7; b >= 0; b--) begin
      if (value[b]) begin
        queue_segment(1'b0, timing.short_us);
        queue_segment(1'b1, timing.long_us);
      end else begin
        queue_segment(1'b0, timing.long_us);
        queue_segment(1'b1, timing.short_us);
      end
    end
    queue_segment(1'b0, timing.short_us);
    queue_segment(1'b1, '0);
  endfunction

  // Works out the segment run of one accepted level request.
  function automatic void plan_level_request(input logic [7:0] requested);
    logic [7:0] lvl;
    logic [7:0] data_byte;
    segment_t   tail;
    lvl = requested;
    if (lvl > {2'b00, timing.max_level}) lvl = {2'b00, timing.max_level};
    if (lvl == 8'd0) begin
      queue_segment(1'b0, timing.off_hold_us);
      mode_selected_copy = 1'b0;
      n_off++;
    end else begin
      if (!mode_selected_copy) begin
        queue_segment(1'b1, timing.select_high_us);
        queue_segment(1'b0, timing.select_low_us);
        queue_segment(1'b1, timing.select_settle_us);
        mode_selected_copy = 1'b1;
        n_select++;
      end
      data_byte = (lvl - 8'd1) & 8'h1F;
      queue_byte(timing.device_address);
      queue_byte(data_byte);
    end
    tail = segments_due.pop_back();
    tail.last = 1'b1;
    segments_due.push_back(tail);
  endfunction

  // Random idle cycles on the request side between items.
  task automatic sender_gap();
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Offers one level and returns at the edge where it is taken.
  task automatic offer_level(input logic [7:0] lvl);
    sender_gap();
    s_tvalid <= 1'b1;
    s_tdata  <= lvl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_requests++;
  endtask

  // Register write, only once every due segment has come out.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    s_tvalid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg_writes++;
    case (idx)
      REG_DEVICE_ADDRESS:   timing.device_address   = value[ADDR_W-1:0];
      REG_SHORT_US:         timing.short_us         = value;
      REG_LONG_US:          timing.long_us          = value;
      REG_SELECT_HIGH_US:   timing.select_high_us   = value;
      REG_SELECT_LOW_US:    timing.select_low_us    = value;
      REG_SELECT_SETTLE_US: timing.select_settle_us = value;
      REG_OFF_HOLD_US:      timing.off_hold_us      = value;
      REG_MAX_LEVEL:        timing.max_level        = value[MAX_W-1:0];
      default: ;
    endcase
  endtask

  // Random register value, with the extremes and out-of-range cases mixed in.
  function automatic logic [15:0] pick_reg_value(input cfg_reg_t idx);
    int r;
    r = $urandom_range(0, 99);
    if (idx == REG_MAX_LEVEL) begin
      if (r < 6) return {10'($urandom_range(0, 1023)), 6'd0};
      if (r < 18) return {10'($urandom_range(0, 1023)), 6'($urandom_range(33, 63))};
      return {10'($urandom_range(0, 1023)), 6'($urandom_range(1, 32))};
    end
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 60) return 16'($urandom_range(0, 1000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly valid levels, some offs and some above the current maximum.
  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12 || timing.max_level == '0) return 8'd0;
    if (r < 32) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, timing.max_level));
  endfunction

  // Receiving side: checks each taken segment, then decides the next stall.
  always @(posedge clk) begin : segment_check
    segment_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_segments++;
      if (segments_due.size() == 0) begin
        $error("unexpected segment: pin_level %0d hold_us %0d last %0d",
               m_tdata[0], m_tdata[16:1], m_tlast);
        err_count++;
      end else begin
        want = segments_due.pop_front();
        if (m_tdata[0] !== want.pin) begin
          $error("pin_level mismatch: expected %0d, got %0d", want.pin, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[16:1] !== want.hold) begin
          $error("hold_us mismatch: expected %0d, got %0d", want.hold, m_tdata[16:1]);
          err_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, m_tlast);
          err_count++;
        end
      end
    end
    m_tready <= calm || ($urandom_range(0, 99) >= 28);
  end

  initial begin : stimulus
    cfg_reg_t idx;
    logic [7:0] lvl;

    timing.device_address   = RST_DEVICE_ADDRESS;
    timing.short_us         = RST_SHORT_US;
    timing.long_us          = RST_LONG_US;
    timing.select_high_us   = RST_SELECT_HIGH_US;
    timing.select_low_us    = RST_SELECT_LOW_US;
    timing.select_settle_us = RST_SELECT_SETTLE_US;
    timing.off_hold_us      = RST_OFF_HOLD_US;
    timing.max_level        = RST_MAX_LEVEL;
    mode_selected_copy      = 1'b1;

    // Directed table: reset values, saturation, zero and wide maximum, timing extremes.
    script = '{
      '{ROW_OFF, REG_DEVICE_ADDRESS,   16'd0,     16'd3000},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd1,     16'd0},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd32,    16'd0},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd255,   16'd0},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd17,    16'd0},
      '{ROW_CFG, REG_MAX_LEVEL,        16'd0,     16'd0},
      '{ROW_OFF, REG_DEVICE_ADDRESS,   16'd200,   16'd3000},
      '{ROW_OFF, REG_DEVICE_ADDRESS,   16'd0,     16'd3000},
      '{ROW_CFG, REG_MAX_LEVEL,        16'hFFFF,  16'd0},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd63,    16'd0},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd33,    16'd0},
      '{ROW_CFG, REG_OFF_HOLD_US,      16'd0,     16'd0},
      '{ROW_OFF, REG_DEVICE_ADDRESS,   16'd0,     16'd0},
      '{ROW_CFG, REG_OFF_HOLD_US,      16'hFFFF,  16'd0},
      '{ROW_OFF, REG_DEVICE_ADDRESS,   16'd0,     16'd65535},
      '{ROW_CFG, REG_SHORT_US,         16'd0,     16'd0},
      '{ROW_CFG, REG_LONG_US,          16'hFFFF,  16'd0},
      '{ROW_CFG, REG_SELECT_HIGH_US,   16'hFFFF,  16'd0},
      '{ROW_CFG, REG_SELECT_LOW_US,    16'd0,     16'd0},
      '{ROW_CFG, REG_SELECT_SETTLE_US, 16'hFFFF,  16'd0},
      '{ROW_CFG, REG_DEVICE_ADDRESS,   16'hA5FF,  16'd0},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd128,   16'd0},
      '{ROW_OFF, REG_DEVICE_ADDRESS,   16'd0,     16'd65535},
      '{ROW_CFG, REG_DEVICE_ADDRESS,   16'd0,     16'd0},
      '{ROW_CFG, REG_SHORT_US,         16'hFFFF,  16'd0},
      '{ROW_CFG, REG_LONG_US,          16'd0,     16'd0},
      '{ROW_CFG, REG_SELECT_HIGH_US,   16'd0,     16'd0},
      '{ROW_CFG, REG_SELECT_LOW_US,    16'hFFFF,  16'd0},
      '{ROW_CFG, REG_SELECT_SETTLE_US, 16'd0,     16'd0},
      '{ROW_CFG, REG_MAX_LEVEL,        16'd1,     16'd0},
      '{ROW_OFF, REG_DEVICE_ADDRESS,   16'd0,     16'd65535},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd1,     16'd0},
      '{ROW_REQ, REG_DEVICE_ADDRESS,   16'd255,   16'd0},
      '{ROW_CFG, REG_MAX_LEVEL,        16'd32,    16'd0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      case (script[i].kind)
        ROW_CFG: write_reg(script[i].idx, script[i].arg);
        ROW_OFF: begin
          offer_level(script[i].arg[7:0]);
          mode_selected_copy = 1'b0;
          n_off++;
          segments_due.push_back('{1'b0, script[i].hold, 1'b1});
        end
        default: begin
          offer_level(script[i].arg[7:0]);
          plan_level_request(script[i].arg[7:0]);
        end
      endcase
    end

    // Random requests in phases, with register changes between phases.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 45 == 0) begin
        repeat ($urandom_range(1, 3)) begin
          idx = cfg_reg_t'($urandom_range(0, 7));
          write_reg(idx, pick_reg_value(idx));
        end
      end
      calm = (k >= 200 && k < 290);
      lvl = pick_level();
      offer_level(lvl);
      plan_level_request(lvl);
    end

    s_tvalid <= 1'b0;
    calm = 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests (%0d off, %0d with mode select), %0d segments checked.",
             n_requests, n_off, n_select, n_segments);
    $display("Register writes: %0d, all eight registers including their extremes.",
             n_cfg_writes);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/owb_pkg.sv
design/owb_cfg_regs.sv
design/owb_seq.sv
design/one_wire_backlight_sender.sv
tb/sv/tb_one_wire_backlight_sender.sv
